FILE: hdl/compacting_array_list_macros.svh
// Assertion shorthands shared by the list logic.
// Each expects signals named clk and rst_n in the scope of its use.
`ifndef COMPACTING_ARRAY_LIST_MACROS_SVH
`define COMPACTING_ARRAY_LIST_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CAL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define CAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cal_pkg.sv
package cal_pkg;

  // Action codes carried on in_tuser
  localparam logic [2:0] ACT_APPEND_ZERO  = 3'd0;
  localparam logic [2:0] ACT_APPEND_VALUE = 3'd1;
  localparam logic [2:0] ACT_REMOVE       = 3'd2;
  localparam logic [2:0] ACT_READ         = 3'd3;
  localparam logic [2:0] ACT_CLEAR        = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Fixed field widths of the channels
  localparam int ACTION_W = 3;
  localparam int POS_W    = 5;
  localparam int RUN_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int RDATA_W  = 32;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int LIMIT_W  = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_POST  = 4'b1000
  } cal_state_t;

  // Port strobes from the sequencer to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cal_mem_ctl_t;

endpackage

FILE: hdl/cal_store.sv
module cal_store
  import cal_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int ITEM_BITS = 32,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  cal_mem_ctl_t         mem_ctl,
  input  logic [AW-1:0]        waddr,
  input  logic [ITEM_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [ITEM_BITS-1:0] rdata
);

  logic [ITEM_BITS-1:0] mem [DEPTH];
  logic [ITEM_BITS-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/cal_ctrl.sv
`include "compacting_array_list_macros.svh"

module cal_ctrl
  import cal_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int ITEM_BITS = 32,
  localparam int AW       = $clog2(DEPTH),
  localparam int CNTW     = $clog2(DEPTH + 1),
  localparam int CW       = (CNTW > 7) ? CNTW : 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request side
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [POS_W-1:0]     position,
  input  logic [RUN_W-1:0]     run_length,
  input  logic [VALUE_W-1:0]   value,
  input  logic [CW-1:0]        cap,
  // result side
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [RDATA_W-1:0]   out_read_data,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [COUNT_W-1:0]   out_entry_count,
  output logic                 out_is_full,
  // entry store
  output cal_mem_ctl_t         mem_ctl,
  output logic [AW-1:0]        mem_waddr,
  output logic [ITEM_BITS-1:0] mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [ITEM_BITS-1:0] mem_rdata
);

  cal_state_t state_r, state_nxt;
  logic [CNTW-1:0] used_r, used_nxt;
  logic [CNTW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] end_r, end_nxt;
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic            pend_r, pend_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [RDATA_W-1:0]  res_data_r, res_data_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [RDATA_W-1:0]  out_data_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_full_r;

  logic          accept;
  logic          load_out;
  logic [CW-1:0] use_w, pos_w, run_w, end_w;
  logic          shift_rd;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_POST) && (!out_valid_r || out_ready);

  assign use_w    = CW'(used_r);
  assign pos_w    = CW'(position);
  assign run_w    = CW'(run_length);
  assign end_w    = pos_w + run_w;
  assign shift_rd = (state_r == S_SHIFT) && (rd_ptr_r < end_r);

  // Sequence each request: check, touch the store, then post the result
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    rd_ptr_nxt     = rd_ptr_r;
    end_nxt        = end_r;
    wr_ptr_nxt     = wr_ptr_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_slot_nxt   = res_slot_r;
    mem_ctl        = '0;
    mem_waddr      = wr_ptr_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = rd_ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_DONE;
          res_data_nxt   = '0;
          res_slot_nxt   = '0;
          state_nxt      = S_POST;
          unique case (action)
            ACT_APPEND_ZERO, ACT_APPEND_VALUE: begin
              if (use_w >= cap) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = used_r[AW-1:0];
                mem_wdata     = (action == ACT_APPEND_VALUE) ? ITEM_BITS'(value) : '0;
                res_slot_nxt  = SLOT_W'(used_r);
                used_nxt      = CNTW'(use_w + CW'(1));
              end
            end
            ACT_REMOVE: begin
              if (run_length == '0 || pos_w >= use_w || end_w > use_w) begin
                res_status_nxt = ST_RANGE;
              end else begin
                used_nxt   = CNTW'(use_w - run_w);
                rd_ptr_nxt = CNTW'(end_w);
                wr_ptr_nxt = pos_w[AW-1:0];
                end_nxt    = used_r;
                pend_nxt   = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            ACT_READ: begin
              if (pos_w >= use_w) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = pos_w[AW-1:0];
                state_nxt     = S_READ;
              end
            end
            ACT_CLEAR: begin
              used_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_data_nxt = RDATA_W'(mem_rdata);
        state_nxt    = S_POST;
      end
      S_SHIFT: begin
        // read one entry ahead, write the previous one down by the run
        mem_ctl.rd_en = shift_rd;
        mem_ctl.wr_en = pend_r;
        if (shift_rd) begin
          rd_ptr_nxt = CNTW'(rd_ptr_r + 1'b1);
        end
        if (pend_r) begin
          wr_ptr_nxt = AW'(wr_ptr_r + 1'b1);
        end
        pend_nxt = shift_rd;
        if (!shift_rd && !pend_r) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the output transfer until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pointers and result payload
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    end_r        <= end_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_slot_r   <= res_slot_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_slot_r   <= res_slot_r;
      out_count_r  <= COUNT_W'(used_r);
      out_full_r   <= (use_w >= cap);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_data_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;
  assign out_is_full     = out_full_r;

  // Checks
  `CAL_ASSERT_ALWAYS(a_count_bound, used_r <= CNTW'(DEPTH), "entry count above depth")
  `CAL_ASSERT_SAME(a_shift_order, mem_ctl.wr_en && mem_ctl.rd_en && state_r == S_SHIFT, CW'(mem_waddr) < CW'(mem_raddr), "shift write overtook read")
  `CAL_ASSERT_SAME(a_shift_inside, state_r == S_SHIFT, rd_ptr_r <= end_r && end_r <= CNTW'(DEPTH), "shift read beyond old end")
  `CAL_ASSERT_NEXT(a_post_loads, load_out, out_valid_r && state_r == S_IDLE, "result not posted")

endmodule

FILE: hdl/compacting_array_list.sv
// Compacting array list: a dense list of entries with a programmable capacity.
// Input channel (in_): one request per transfer; in_tuser holds the action
// (append zero, append value, remove run, read, clear), in_tdata its operands.
// Output channel (out_): exactly one result per request, in request order,
// carrying status, read data, append slot, entry count and the full flag.
// cfg_we/cfg_wdata set the capacity limit (0 or above DEPTH means DEPTH);
// write it only while no request is outstanding.
// Append, clear and rejected requests go straight to the result stage; a read
// first reads the entry store, and a remove shifts the entries behind the
// run down through the store's single write port, moving one entry a cycle.
// One request is in the block at a time; the next is taken the cycle after the
// previous result is loaded into the output register, and a new request can be
// accepted while the receiver stalls on that result.
// A stalled result holds until taken.
// Reset empties the list and loads a capacity limit of 32; the store itself
// is not cleared and needs no sweep, as entries beyond the count are never read.
module compacting_array_list
  import cal_pkg::*;
#(
  parameter int DEPTH     = 32,
  parameter int ITEM_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [4:0] position, [10:5] run_length, [42:11] value, [47:43] zero
  input  logic [47:0]        in_tdata,
  // [2:0] action
  input  logic [2:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [1:0] status, [33:2] read_data, [38:34] slot, [44:39] entry_count,
  // [45] is_full, [47:46] zero
  output logic [47:0]        out_tdata,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CW   = (CNTW > 7) ? CNTW : 7;

  logic [LIMIT_W-1:0]   limit_r;
  logic [CW-1:0]        limit_w;
  logic [CW-1:0]        cap;
  cal_mem_ctl_t         mem_ctl;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [ITEM_BITS-1:0] mem_wdata, mem_rdata;
  logic [STATUS_W-1:0]  res_status;
  logic [RDATA_W-1:0]   res_data;
  logic [SLOT_W-1:0]    res_slot;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_full;

  // Capacity limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Saturate the limit to the store depth; zero also selects the full depth
  assign limit_w = CW'(limit_r);
  assign cap     = (limit_r == '0 || limit_w > CW'(DEPTH)) ? CW'(DEPTH) : limit_w;

  cal_ctrl #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .action          (in_tuser[ACTION_W-1:0]),
    .position        (in_tdata[4:0]),
    .run_length      (in_tdata[10:5]),
    .value           (in_tdata[42:11]),
    .cap             (cap),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (res_status),
    .out_read_data   (res_data),
    .out_slot        (res_slot),
    .out_entry_count (res_count),
    .out_is_full     (res_full),
    .mem_ctl         (mem_ctl),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  cal_store #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {2'b00, res_full, res_count, res_slot, res_data, res_status};

endmodule
